FILE: design/ipm_pkg.sv
// Shared types and constants of the inter-processor interrupt mailbox.
// Register offsets, error codes, decoded access descriptor and memory geometry.
// No dependencies.
`default_nettype none

package ipm_pkg;

  // Register offsets within the low address byte
  localparam logic [7:0] STATUS_OFFSET = 8'h00;
  localparam logic [7:0] ENABLE_OFFSET = 8'h04;
  localparam logic [7:0] SET_OFFSET    = 8'h08;
  localparam logic [7:0] CLEAR_OFFSET  = 8'h0C;
  localparam logic [7:0] MBOX_FIRST    = 8'h20;
  localparam logic [7:0] MBOX_LAST     = 8'h3C;

  // Error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_READ_ONLY  = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN    = 2'd2;
  localparam logic [1:0] ERR_MISALIGNED = 2'd3;

  // Configuration reset
  localparam logic [5:0] NODE_POS_RESET = 6'd44;

  // Memory geometry: per-core table holds {enable, status}
  localparam int CORE_DEPTH = 16;
  localparam int CORE_W     = 64;
  localparam int MBOX_DEPTH = 64;
  localparam int MBOX_W     = 64;

  typedef enum logic [2:0] {
    KIND_STATUS,
    KIND_ENABLE,
    KIND_SET,
    KIND_CLEAR,
    KIND_MBOX,
    KIND_NONE
  } reg_kind_t;

  // Decoded access descriptor
  typedef struct packed {
    logic [3:0] core_no;
    logic [1:0] word;
    reg_kind_t  kind;
    logic [1:0] err;
  } dec_t;

endpackage

`default_nettype wire

FILE: design/ipm_decode.sv
// Address decoder of the mailbox: core index, register kind, mailbox word, error.
// Depends on ipm_pkg.
`default_nettype none

module ipm_decode (
  input  wire logic          mode,
  input  wire logic [47:0]   access_address,
  input  wire logic [3:0]    access_bytes,
  input  wire logic [5:0]    node_pos,
  output ipm_pkg::dec_t      dec
);
  import ipm_pkg::*;

  logic [63:0] addr_ext;
  logic [63:0] shifted;
  logic [7:0]  offset;
  logic [3:0]  align_mask;
  logic [7:0]  mbox_rel;

  // Pick node bits; shifts past the address width select node 0
  assign addr_ext   = {16'd0, access_address};
  assign shifted    = addr_ext >> node_pos;
  assign offset     = access_address[7:0];
  assign align_mask = 4'(access_bytes - 4'd1);
  assign mbox_rel   = 8'(offset - MBOX_FIRST);

  // Classify the offset and rank the errors, alignment first
  always_comb begin
    dec.core_no = {shifted[1:0], access_address[9:8]};
    dec.word    = mbox_rel[4:3];
    dec.kind    = KIND_NONE;
    dec.err     = ERR_OK;
    if ((offset[3:0] & align_mask) != 4'd0) begin
      dec.err = ERR_MISALIGNED;
    end else if (offset == STATUS_OFFSET) begin
      dec.kind = KIND_STATUS;
      if (mode) dec.err = ERR_READ_ONLY;
    end else if (offset == ENABLE_OFFSET) begin
      dec.kind = KIND_ENABLE;
    end else if (offset == SET_OFFSET) begin
      dec.kind = KIND_SET;
    end else if (offset == CLEAR_OFFSET) begin
      dec.kind = KIND_CLEAR;
    end else if (offset >= MBOX_FIRST && offset <= MBOX_LAST) begin
      dec.kind = KIND_MBOX;
    end else begin
      dec.err = ERR_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

FILE: design/ipm_ram.sv
// Synchronous single-read single-write memory with per-entry valid bits.
// Unwritten entries read as zero; read data is registered. Depends on ipm_pkg.
`default_nettype none

module ipm_ram #(
  parameter int DATA_W = ipm_pkg::CORE_W,
  parameter int DEPTH  = ipm_pkg::CORE_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);
  import ipm_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

FILE: design/ipi_mailbox_registers.sv
// Inter-processor interrupt mailbox, top level: decode, two memories, sequencer.
// The result is registered in the execute state and strobed on done; a new access is
// accepted only while idle, after the read-then-write pass over the synchronous memories.
// The receiver cannot stall: each result is shown for one cycle on done.
// Synchronous reset clears status, enables and mailboxes and sets the node position to 44.
`default_nettype none

module ipi_mailbox_registers (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [47:0] access_address,
  input  wire logic [3:0]  access_bytes,
  input  wire logic [63:0] write_data,
  output logic             done,
  output logic [63:0]      read_data,
  output logic             irq_raise,
  output logic             irq_lower,
  output logic [3:0]       irq_core,
  output logic [1:0]       access_error
);
  import ipm_pkg::*;

  localparam int CORE_AW = $clog2(CORE_DEPTH);
  localparam int MBOX_AW = $clog2(MBOX_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t          state;
  logic [5:0]      node_pos;
  dec_t            dec_in;
  dec_t            dec_q;
  logic            mode_q;
  logic [63:0]     wdata_q;
  logic            accept;

  logic [CORE_W-1:0] core_rd;
  logic [MBOX_W-1:0] mbox_rd;
  logic              core_we;
  logic              mbox_we;
  logic [CORE_W-1:0] core_wr;
  logic [31:0]       status_cur;
  logic [31:0]       enable_cur;
  logic [31:0]       status_next;
  logic [31:0]       enable_next;
  logic [63:0]       rdata_next;
  logic              raise_next;
  logic              lower_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Hold the node-select position
  always_ff @(posedge clk) begin
    if (rst) begin
      node_pos <= NODE_POS_RESET;
    end else if (cfg_we) begin
      node_pos <= cfg_wdata;
    end
  end

  ipm_decode u_decode (
    .mode           (mode),
    .access_address (access_address),
    .access_bytes   (access_bytes),
    .node_pos       (node_pos),
    .dec            (dec_in)
  );

  ipm_ram #(
    .DATA_W (CORE_W),
    .DEPTH  (CORE_DEPTH)
  ) u_core_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (CORE_AW'(dec_in.core_no)),
    .rd_data (core_rd),
    .wr_en   (core_we),
    .wr_addr (CORE_AW'(dec_q.core_no)),
    .wr_data (core_wr)
  );

  ipm_ram #(
    .DATA_W (MBOX_W),
    .DEPTH  (MBOX_DEPTH)
  ) u_mbox_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (MBOX_AW'({dec_in.core_no, dec_in.word})),
    .rd_data (mbox_rd),
    .wr_en   (mbox_we),
    .wr_addr (MBOX_AW'({dec_q.core_no, dec_q.word})),
    .wr_data (wdata_q)
  );

  assign enable_cur = core_rd[63:32];
  assign status_cur = core_rd[31:0];
  assign core_wr    = {enable_next, status_next};

  // Modify the fetched entry and pick the read data
  always_comb begin
    enable_next = enable_cur;
    status_next = status_cur;
    rdata_next  = '0;
    raise_next  = 1'b0;
    lower_next  = 1'b0;
    core_we     = 1'b0;
    mbox_we     = 1'b0;
    if (state == ST_EXEC && dec_q.err == ERR_OK) begin
      case (dec_q.kind)
        KIND_STATUS: begin
          if (!mode_q) rdata_next = {32'd0, status_cur};
        end
        KIND_ENABLE: begin
          if (mode_q) begin
            enable_next = wdata_q[31:0];
            core_we     = 1'b1;
          end else begin
            rdata_next = {32'd0, enable_cur};
          end
        end
        KIND_SET: begin
          if (mode_q) begin
            status_next = status_cur | wdata_q[31:0];
            raise_next  = 1'b1;
            core_we     = 1'b1;
          end
        end
        KIND_CLEAR: begin
          if (mode_q) begin
            status_next = status_cur & ~wdata_q[31:0];
            lower_next  = (status_next == 32'd0);
            core_we     = 1'b1;
          end
        end
        KIND_MBOX: begin
          if (mode_q) mbox_we = 1'b1;
          else        rdata_next = mbox_rd;
        end
        default: ;
      endcase
    end
  end

  // Sequence the transaction and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            dec_q   <= dec_in;
            mode_q  <= mode;
            wdata_q <= write_data;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done         <= 1'b1;
          read_data    <= rdata_next;
          irq_raise    <= raise_next;
          irq_lower    <= lower_next;
          irq_core     <= dec_q.core_no;
          access_error <= dec_q.err;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An accepted transaction occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not make the block busy");

  // A result strobe follows only from the execute step
  a_done_from_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC) && !busy)
    else $error("result strobe without an execute step");

  // Interrupt changes come only from clean writes
  a_irq_clean: assert property (@(posedge clk) disable iff (rst)
    done && (irq_raise || irq_lower) |-> access_error == ERR_OK && read_data == 64'd0)
    else $error("interrupt change on a failed or read transaction");

  // Raise and lower never occur together
  a_irq_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(irq_raise && irq_lower))
    else $error("raise and lower in the same transaction");

endmodule

`default_nettype wire
